FILE: rtl/core/mlfq_pkg.sv
// Package for the multilevel feedback queue scheduler.
// Holds sizing constants, request and status codes and the sequencer state type; no dependencies.
package mlfq_pkg;
   localparam int MAX_TASKS  = 64;
   localparam int NUM_LEVELS = 3;

   localparam logic [2:0] REQ_ADD      = 3'd0;
   localparam logic [2:0] REQ_FINISH   = 3'd1;
   localparam logic [2:0] REQ_TICK     = 3'd2;
   localparam logic [2:0] REQ_DISPATCH = 3'd3;
   localparam logic [2:0] REQ_SLICE    = 3'd4;

   localparam logic [2:0] ST_ACK       = 3'd0;
   localparam logic [2:0] ST_DISPATCH  = 3'd1;
   localparam logic [2:0] ST_ALL_DONE  = 3'd2;
   localparam logic [2:0] ST_NONE      = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   localparam logic [0:0] CSR_SLICE    = 1'd0;
   localparam logic [0:0] CSR_BOOST    = 1'd1;

   localparam logic [23:0] SLICE_RESET = 24'd125000;
   localparam logic [23:0] BOOST_RESET = 24'd2000000;
   localparam logic [23:0] TIMER_MAX   = 24'hFFFFFF;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DONE_SCAN,
      S_BOOST_RD,
      S_BOOST_DN,
      S_BOOST_WR,
      S_PICK,
      S_PICK_RD,
      S_PICK_DN,
      S_PICK_CHK,
      S_MOVE_WR,
      S_SLICE_RD,
      S_SLICE_CHK,
      S_SLICE_MV,
      S_SLICE_MW,
      S_RESP
   } state_type;
endpackage

FILE: rtl/core/mlfq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mlfq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: rtl/core/multilevel_feedback_queue_scheduler_unit.sv
// Multilevel feedback queue scheduler: add, finish, tick, dispatch, slice end.
// Add, finish, tick, unknown types and a slice end that fails its demotion checks go from accept to the
// result beat. A slice end that passes them reads its pick slot and checks the task; on a match it moves
// the last entry into the slot and appends the task one level down. Dispatch scans done marks, boosts if
// due, then picks with lazy removal. One item at a time; busy through the result beat; receiver cannot stall.
// Reset (synchronous, active high) clears sizes, pointers, counters, timer and pick; RAMs are written
// before they are read.
module multilevel_feedback_queue_scheduler_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_type,
   input  logic [5:0]  req_task_id,
   input  logic [23:0] req_used_ticks,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_chosen_task,
   output logic [1:0]  rsp_chosen_level,
   output logic        rsp_boosted,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [23:0] csr_data
);
   import mlfq_pkg::*;

   localparam int TW  = $clog2(MAX_TASKS);       // slot / task index width
   localparam int CW  = $clog2(MAX_TASKS + 1);   // count width
   localparam int LW  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int QD  = NUM_LEVELS * MAX_TASKS;
   localparam int AW  = $clog2(QD);

   state_type state_ff, state_in;

   logic [23:0] slice_ff, slice_in, boost_ff, boost_in, timer_ff, timer_in;
   logic [CW-1:0] size_ff [NUM_LEVELS];
   logic [CW-1:0] size_in [NUM_LEVELS];
   logic [TW-1:0] ptr_ff [NUM_LEVELS];
   logic [TW-1:0] ptr_in [NUM_LEVELS];
   logic [CW-1:0] count_ff, count_in;
   logic [LW-1:0] plvl_ff, plvl_in;
   logic [TW-1:0] pslot_ff, pslot_in;
   logic [5:0] ptask_ff, ptask_in;
   logic pvalid_ff, pvalid_in;

   // working registers
   logic [CW-1:0] idx_ff, idx_in;     // scan / copy index
   logic [LW-1:0] lvl_ff, lvl_in;     // level walked
   logic [TW-1:0] slot_ff, slot_in;
   logic [5:0]  tsk_ff, tsk_in;       // task read from the queue, held for its done lookup
   logic        bst_ff, bst_in;
   logic [2:0]  st_ff, st_in;
   logic [5:0]  otask_ff, otask_in;
   logic [LW-1:0] olvl_ff, olvl_in;

   // queue RAM port
   logic          we;
   logic [AW-1:0] waddr, raddr;
   logic [TW-1:0] wdata, rdata;

   // done mark RAM port
   logic          d_we;
   logic [TW-1:0] d_waddr, d_raddr;
   logic          d_wdata, d_rdata;

   mlfq_ram #(.WIDTH(TW), .DEPTH(QD)) u_queue_ram (
      .clock(clock), .wr_en(we), .wr_addr(waddr), .wr_data(wdata),
      .rd_addr(raddr), .rd_data(rdata)
   );

   mlfq_ram #(.WIDTH(1), .DEPTH(MAX_TASKS)) u_done_ram (
      .clock(clock), .wr_en(d_we), .wr_addr(d_waddr), .wr_data(d_wdata),
      .rd_addr(d_raddr), .rd_data(d_rdata)
   );

   function automatic logic [AW-1:0] qaddr(input logic [LW-1:0] l, input logic [TW-1:0] s);
      qaddr = AW'(AW'(l) * AW'(MAX_TASKS) + AW'(s));
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         slice_ff  <= SLICE_RESET;
         boost_ff  <= BOOST_RESET;
         timer_ff  <= '0;
         count_ff  <= '0;
         plvl_ff   <= '0;
         pslot_ff  <= '0;
         ptask_ff  <= '0;
         pvalid_ff <= 1'b0;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            size_ff[i] <= '0;
            ptr_ff[i]  <= '0;
         end
      end else begin
         state_ff  <= state_in;
         slice_ff  <= slice_in;
         boost_ff  <= boost_in;
         timer_ff  <= timer_in;
         count_ff  <= count_in;
         plvl_ff   <= plvl_in;
         pslot_ff  <= pslot_in;
         ptask_ff  <= ptask_in;
         pvalid_ff <= pvalid_in;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            size_ff[i] <= size_in[i];
            ptr_ff[i]  <= ptr_in[i];
         end
      end
      idx_ff   <= idx_in;
      lvl_ff   <= lvl_in;
      slot_ff  <= slot_in;
      tsk_ff   <= tsk_in;
      bst_ff   <= bst_in;
      st_ff    <= st_in;
      otask_ff <= otask_in;
      olvl_ff  <= olvl_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_status       = st_ff;
   assign rsp_chosen_task  = otask_ff;
   assign rsp_chosen_level = 2'(olvl_ff);
   assign rsp_boosted      = bst_ff;

   logic [CW-1:0] n_cur;
   logic [LW-1:0] top_lvl;
   logic          any_nonempty;
   logic [TW-1:0] pick_idx;
   logic [5:0]    rtask;
   logic [CW:0]   ptr_next;

   always_comb begin
      // highest-priority (lowest-numbered) non-empty level
      top_lvl = '0;
      any_nonempty = 1'b0;
      for (int q = NUM_LEVELS - 1; q >= 0; q--) begin
         if (size_ff[q] != '0) begin
            top_lvl = LW'(q);
            any_nonempty = 1'b1;
         end
      end
      n_cur = size_ff[lvl_ff];
      // pointer < size is kept, except after removals; one compare-subtract suffices
      pick_idx = (CW'(ptr_ff[lvl_ff]) >= n_cur) ? TW'(CW'(ptr_ff[lvl_ff]) - n_cur)
                                                  : ptr_ff[lvl_ff];
      ptr_next = (CW + 1)'(pick_idx) + 1'b1;
      rtask = 6'(rdata);
   end

   always_comb begin
      state_in = state_ff;
      slice_in = slice_ff; boost_in = boost_ff; timer_in = timer_ff;
      size_in = size_ff; ptr_in = ptr_ff;
      count_in = count_ff;
      plvl_in = plvl_ff; pslot_in = pslot_ff; ptask_in = ptask_ff; pvalid_in = pvalid_ff;
      idx_in = idx_ff; lvl_in = lvl_ff; slot_in = slot_ff; tsk_in = tsk_ff;
      bst_in = bst_ff; st_in = st_ff; otask_in = otask_ff; olvl_in = olvl_ff;
      we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
      d_we = 1'b0; d_waddr = '0; d_wdata = 1'b0; d_raddr = '0;

      case (state_ff)
         S_IDLE: begin
            if (csr_valid) begin
               if (csr_index == CSR_SLICE) slice_in = csr_data;
               else                        boost_in = csr_data;
            end
            if (start) begin
               st_in = ST_ACK; otask_in = '0; olvl_in = '0; bst_in = 1'b0;
               idx_in = '0;
               state_in = S_RESP;
               case (req_type)
                  REQ_ADD: begin
                     if (count_ff == CW'(MAX_TASKS)) begin
                        st_in = ST_FULL;
                     end else begin
                        // append new id to level 0, clear its done mark
                        d_we = 1'b1; d_waddr = TW'(count_ff); d_wdata = 1'b0;
                        we = 1'b1; waddr = qaddr('0, TW'(size_ff[0]));
                        wdata = TW'(count_ff);
                        size_in[0] = size_ff[0] + 1'b1;
                        otask_in = 6'(count_ff);
                        count_in = count_ff + 1'b1;
                     end
                  end
                  REQ_FINISH: begin
                     if (CW'(req_task_id) < count_ff) begin
                        d_we = 1'b1; d_waddr = TW'(req_task_id); d_wdata = 1'b1;
                     end
                  end
                  REQ_TICK: begin
                     if (timer_ff != TIMER_MAX) timer_in = timer_ff + 1'b1;
                  end
                  REQ_DISPATCH: begin
                     // fetch the first done mark for the scan
                     d_raddr = '0;
                     state_in = S_DONE_SCAN;
                  end
                  REQ_SLICE: begin
                     if (pvalid_ff && req_used_ticks >= slice_ff &&
                         32'(plvl_ff) + 1 < NUM_LEVELS &&
                         CW'(pslot_ff) < size_ff[plvl_ff]) begin
                        state_in = S_SLICE_RD;
                     end
                     pvalid_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         S_DONE_SCAN: begin
            // walk done marks one a cycle; d_rdata holds the mark of entry idx
            if (idx_ff == count_ff) begin
               pvalid_in = 1'b0; st_in = ST_ALL_DONE; state_in = S_RESP;
            end else if (!d_rdata) begin
               if (timer_ff >= boost_ff) begin
                  timer_in = '0; bst_in = 1'b1;
                  lvl_in = LW'(1); idx_in = '0;
                  state_in = S_BOOST_RD;
               end else begin
                  state_in = S_PICK;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
               d_raddr = TW'(idx_ff + 1'b1);
            end
         end
         S_BOOST_RD: begin
            // copy unfinished entries of level lvl to level 0
            if (idx_ff == size_ff[lvl_ff]) begin
               size_in[lvl_ff] = '0; ptr_in[lvl_ff] = '0;
               idx_in = '0;
               if (32'(lvl_ff) + 1 >= NUM_LEVELS) state_in = S_PICK;
               else lvl_in = lvl_ff + 1'b1;
            end else begin
               raddr = qaddr(lvl_ff, TW'(idx_ff));
               state_in = S_BOOST_DN;
            end
         end
         S_BOOST_DN: begin
            // hold the task and look up its done mark
            tsk_in = rtask;
            d_raddr = rdata;
            state_in = S_BOOST_WR;
         end
         S_BOOST_WR: begin
            if (!d_rdata && size_ff[0] < CW'(MAX_TASKS)) begin
               we = 1'b1; waddr = qaddr('0, TW'(size_ff[0])); wdata = TW'(tsk_ff);
               size_in[0] = size_ff[0] + 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            state_in = S_BOOST_RD;
         end
         S_PICK: begin
            if (!any_nonempty) begin
               pvalid_in = 1'b0; st_in = ST_NONE; state_in = S_RESP;
            end else begin
               lvl_in = top_lvl;
               state_in = S_PICK_RD;
            end
         end
         S_PICK_RD: begin
            slot_in = pick_idx;
            raddr = qaddr(lvl_ff, pick_idx);
            ptr_in[lvl_ff] = (ptr_next >= (CW + 1)'(n_cur)) ? '0 : TW'(ptr_next);
            state_in = S_PICK_DN;
         end
         S_PICK_DN: begin
            tsk_in = rtask;
            d_raddr = rdata;
            state_in = S_PICK_CHK;
         end
         S_PICK_CHK: begin
            if (d_rdata) begin
               // lazy removal: swap last entry into slot
               raddr = qaddr(lvl_ff, TW'(size_ff[lvl_ff] - 1'b1));
               state_in = S_MOVE_WR;
            end else begin
               plvl_in = lvl_ff; pslot_in = slot_ff; ptask_in = tsk_ff; pvalid_in = 1'b1;
               st_in = ST_DISPATCH; otask_in = tsk_ff; olvl_in = lvl_ff;
               state_in = S_RESP;
            end
         end
         S_MOVE_WR: begin
            we = 1'b1; waddr = qaddr(lvl_ff, slot_ff); wdata = rdata;
            size_in[lvl_ff] = size_ff[lvl_ff] - 1'b1;
            state_in = S_PICK;
         end
         S_SLICE_RD: begin
            raddr = qaddr(plvl_ff, pslot_ff);
            state_in = S_SLICE_CHK;
         end
         S_SLICE_CHK: begin
            if (rtask == ptask_ff) begin
               raddr = qaddr(plvl_ff, TW'(size_ff[plvl_ff] - 1'b1));
               state_in = S_SLICE_MV;
            end else begin
               state_in = S_RESP;
            end
         end
         S_SLICE_MV: begin
            we = 1'b1; waddr = qaddr(plvl_ff, pslot_ff); wdata = rdata;
            size_in[plvl_ff] = size_ff[plvl_ff] - 1'b1;
            state_in = S_SLICE_MW;
         end
         S_SLICE_MW: begin
            // append to next level down
            if (size_ff[plvl_ff + 1'b1] < CW'(MAX_TASKS)) begin
               we = 1'b1; waddr = qaddr(plvl_ff + 1'b1, TW'(size_ff[plvl_ff + 1'b1]));
               wdata = TW'(ptask_ff);
               size_in[plvl_ff + 1'b1] = size_ff[plvl_ff + 1'b1] + 1'b1;
            end
            state_in = S_RESP;
         end
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

`ifndef SYNTH
   a_resp_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("result beat not followed by idle");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted item did not raise busy");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_TASKS)) else $error("task count overflow");
   a_dispatch_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_DISPATCH) |-> pvalid_ff)
      else $error("dispatch without recorded pick");
`endif
endmodule

FILE: bench/multilevel_feedback_queue_scheduler_unit_test.sv
`timescale 1ns / 1ps
// Testbench for multilevel_feedback_queue_scheduler_unit: directed table, then random beats.
// Depends on mlfq_pkg and the unit; checks every response against an in-bench scheduler model or a pinned row.
module multilevel_feedback_queue_scheduler_unit_test;
   import mlfq_pkg::*;

   localparam int TASKS  = 64;
   localparam int LEVELS = 3;
   localparam longint CYCLE_LIMIT = 4000000;

   typedef struct packed {
      logic [2:0] status;
      logic [5:0] chosen;
      logic [1:0] level;
      logic       boosted;
   } outcome_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [5:0]  tid;
      logic [23:0] used;
      logic        typed;
      outcome_type want;
   } row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_type;
   logic [5:0]  req_task_id;
   logic [23:0] req_used_ticks;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [5:0]  rsp_chosen_task;
   logic [1:0]  rsp_chosen_level;
   logic        rsp_boosted;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [23:0] csr_data;

   multilevel_feedback_queue_scheduler_unit dut (.*);

   // Scheduler shadow state, kept in step with every accepted beat.
   logic [23:0] slice_len, boost_len, boost_count;
   logic [5:0]  queue_mem [LEVELS][TASKS];
   int          queue_len [LEVELS];
   int          rr_ptr [LEVELS];
   bit          finished [TASKS];
   int          added;
   int          pick_lvl, pick_slot;
   logic [5:0]  pick_id;
   bit          pick_live;

   outcome_type pending_q[$];
   int          errors;
   longint      cycles;

   // Pinned expectation for typed table rows; driven with the request beat.
   logic        pin_on;
   outcome_type pin_val;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void drop_slot(int lvl, int slot);
      queue_mem[lvl][slot] = queue_mem[lvl][queue_len[lvl] - 1];
      queue_len[lvl]--;
   endfunction

   function automatic void push_entry(int lvl, logic [5:0] id);
      if (queue_len[lvl] < TASKS) begin
         queue_mem[lvl][queue_len[lvl]] = id;
         queue_len[lvl]++;
      end
   endfunction

   function automatic outcome_type schedule_step(logic [2:0] kind, logic [5:0] tid,
                                                 logic [23:0] used);
      outcome_type r;
      bit       all_fin;
      int       lvl, idx;
      logic [5:0] t;
      r = '0;
      case (kind)
         REQ_ADD: begin
            if (added >= TASKS) begin
               r.status = ST_FULL;
            end else begin
               finished[added] = 1'b0;
               push_entry(0, added[5:0]);
               r.chosen = added[5:0];
               added++;
            end
         end
         REQ_FINISH: if (tid < added) finished[tid] = 1'b1;
         REQ_TICK: if (boost_count != TIMER_MAX) boost_count++;
         REQ_DISPATCH: begin
            all_fin = 1'b1;
            for (int i = 0; i < added; i++) if (!finished[i]) all_fin = 1'b0;
            if (all_fin) begin
               pick_live = 1'b0;
               r.status = ST_ALL_DONE;
               return r;
            end
            if (boost_count >= boost_len) begin
               // Raise every unfinished lower-level entry back to the top level.
               for (int q = 1; q < LEVELS; q++) begin
                  for (int j = 0; j < queue_len[q]; j++)
                     if (!finished[queue_mem[q][j]]) push_entry(0, queue_mem[q][j]);
                  queue_len[q] = 0;
                  rr_ptr[q] = 0;
               end
               boost_count = '0;
               r.boosted = 1'b1;
            end
            forever begin
               lvl = -1;
               for (int q = LEVELS - 1; q >= 0; q--) if (queue_len[q] > 0) lvl = q;
               if (lvl < 0) break;
               idx = rr_ptr[lvl] % queue_len[lvl];
               t = queue_mem[lvl][idx];
               rr_ptr[lvl] = (rr_ptr[lvl] + 1) % queue_len[lvl];
               if (finished[t]) begin
                  drop_slot(lvl, idx);
                  continue;
               end
               pick_lvl = lvl;
               pick_slot = idx;
               pick_id = t;
               pick_live = 1'b1;
               r.status = ST_DISPATCH;
               r.chosen = t;
               r.level = lvl[1:0];
               return r;
            end
            pick_live = 1'b0;
            r.status = ST_NONE;
         end
         REQ_SLICE: begin
            // Demote only when the recorded pick still sits in its slot.
            if (pick_live && used >= slice_len && pick_lvl + 1 < LEVELS &&
                pick_slot < queue_len[pick_lvl] &&
                queue_mem[pick_lvl][pick_slot] == pick_id) begin
               drop_slot(pick_lvl, pick_slot);
               push_entry(pick_lvl + 1, pick_id);
            end
            pick_live = 1'b0;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   // Monitor: check the response beat first, then predict the request beat.
   always @(posedge clock) begin
      outcome_type want, got, pred;
      if (!reset) begin
         if (rsp_valid) begin
            got = '{rsp_status, rsp_chosen_task, rsp_chosen_level, rsp_boosted};
            if (pending_q.size() == 0) begin
               report("unexpected response status", got.status, -1);
            end else begin
               want = pending_q.pop_front();
               if (got.status != want.status) report("status", got.status, want.status);
               if (got.chosen != want.chosen) report("chosen_task", got.chosen, want.chosen);
               if (got.level != want.level) report("chosen_level", got.level, want.level);
               if (got.boosted != want.boosted) report("boosted", got.boosted, want.boosted);
            end
         end
         if (start && !busy) begin
            pred = schedule_step(req_type, req_task_id, req_used_ticks);
            pending_q.push_back(pin_on ? pin_val : pred);
         end
      end
   end

   // Watchdog: stop a hung run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("multilevel_feedback_queue_scheduler_unit verification failed");
         $finish;
      end
   end

   // Hold start high until the beat is taken; leave it high for back-to-back beats.
   task automatic issue(logic [2:0] kind, logic [5:0] tid, logic [23:0] used,
                        logic typed, outcome_type want);
      start <= 1'b1;
      req_type <= kind;
      req_task_id <= tid;
      req_used_ticks <= used;
      pin_on <= typed;
      pin_val <= want;
      do @(posedge clock); while (busy);
   endtask

   task automatic pause_sender(int pct);
      if ($urandom_range(99) < pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Drain outstanding responses, then write one register.
   task automatic write_reg(logic idx, logic [23:0] value);
      start <= 1'b0;
      do @(posedge clock); while (pending_q.size() != 0);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_SLICE) slice_len = value;
      else boost_len = value;
   endtask

   function automatic logic [2:0] pick_kind();
      int p;
      p = $urandom_range(99);
      if (p < 5)  return REQ_ADD;
      if (p < 11) return REQ_FINISH;
      if (p < 40) return REQ_TICK;
      if (p < 76) return REQ_DISPATCH;
      if (p < 96) return REQ_SLICE;
      return 3'($urandom_range(5, 7));
   endfunction

   function automatic logic [23:0] pick_used();
      case ($urandom_range(3))
         0: return 24'($urandom);
         1: return slice_len;
         2: return (slice_len == 0) ? 24'd0 : slice_len - 24'd1;
         default: return 24'($urandom_range(0, 80));
      endcase
   endfunction

   task automatic random_phase(int count, int idle_pct);
      for (int n = 0; n < count; n++) begin
         issue(pick_kind(), 6'($urandom_range(63)), pick_used(), 1'b0, '0);
         pause_sender(idle_pct);
      end
   endtask

   // Directed rows: typed answers where they are obvious, model elsewhere.
   row_type plan [0:18] = '{
      '{REQ_DISPATCH, 6'd0,  24'd0,        1'b1, '{ST_ALL_DONE, 6'd0, 2'd0, 1'b0}},
      '{REQ_SLICE,    6'd0,  24'hFFFFFF,   1'b1, '{ST_ACK, 6'd0, 2'd0, 1'b0}},
      '{REQ_FINISH,   6'd63, 24'd0,        1'b1, '{ST_ACK, 6'd0, 2'd0, 1'b0}},
      '{3'd7,         6'd63, 24'hFFFFFF,   1'b1, '{ST_ACK, 6'd0, 2'd0, 1'b0}},
      '{REQ_ADD,      6'd0,  24'd0,        1'b1, '{ST_ACK, 6'd0, 2'd0, 1'b0}},
      '{REQ_ADD,      6'd21, 24'd0,        1'b1, '{ST_ACK, 6'd1, 2'd0, 1'b0}},
      '{REQ_ADD,      6'd42, 24'd0,        1'b1, '{ST_ACK, 6'd2, 2'd0, 1'b0}},
      '{REQ_TICK,     6'd0,  24'd0,        1'b1, '{ST_ACK, 6'd0, 2'd0, 1'b0}},
      '{REQ_DISPATCH, 6'd0,  24'd0,        1'b0, '0},
      '{REQ_SLICE,    6'd0,  24'hFFFFFF,   1'b0, '0},
      '{REQ_DISPATCH, 6'd0,  24'd0,        1'b0, '0},
      '{REQ_SLICE,    6'd0,  24'd0,        1'b0, '0},
      '{REQ_SLICE,    6'd0,  24'hFFFFFF,   1'b0, '0},
      '{REQ_FINISH,   6'd1,  24'd0,        1'b1, '{ST_ACK, 6'd0, 2'd0, 1'b0}},
      '{REQ_DISPATCH, 6'd0,  24'd0,        1'b0, '0},
      '{REQ_DISPATCH, 6'd0,  24'd0,        1'b0, '0},
      '{3'd5,         6'd0,  24'd0,        1'b1, '{ST_ACK, 6'd0, 2'd0, 1'b0}},
      '{3'd6,         6'd0,  24'd0,        1'b1, '{ST_ACK, 6'd0, 2'd0, 1'b0}},
      '{REQ_DISPATCH, 6'd0,  24'd0,        1'b0, '0}
   };

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_type = REQ_ADD;
      req_task_id = '0;
      req_used_ticks = '0;
      csr_valid = 1'b0;
      csr_index = CSR_SLICE;
      csr_data = '0;
      pin_on = 1'b0;
      pin_val = '0;
      errors = 0;
      cycles = 0;
      slice_len = SLICE_RESET;
      boost_len = BOOST_RESET;
      boost_count = '0;
      added = 0;
      pick_lvl = 0;
      pick_slot = 0;
      pick_id = '0;
      pick_live = 1'b0;
      for (int q = 0; q < LEVELS; q++) begin
         queue_len[q] = 0;
         rr_ptr[q] = 0;
      end
      for (int i = 0; i < TASKS; i++) finished[i] = 1'b0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table at reset register values.
      foreach (plan[i]) issue(plan[i].kind, plan[i].tid, plan[i].used, plan[i].typed,
                              plan[i].want);

      // Smallest slice and boost: a dispatch after any tick boosts, and any nonzero used_ticks ends the slice.
      write_reg(CSR_SLICE, 24'd1);
      write_reg(CSR_BOOST, 24'd1);
      random_phase(560, 27);

      // Largest values: demotion only at full used_ticks, no boosts.
      write_reg(CSR_SLICE, 24'hFFFFFF);
      write_reg(CSR_BOOST, 24'hFFFFFF);
      random_phase(560, 77);

      // Mid-range settings, back-to-back beats.
      write_reg(CSR_SLICE, 24'($urandom_range(2, 64)));
      write_reg(CSR_BOOST, 24'($urandom_range(2, 40)));
      random_phase(560, 0);

      start <= 1'b0;
      do @(posedge clock); while (pending_q.size() != 0);
      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("multilevel_feedback_queue_scheduler_unit verification clean");
      else
         $display("multilevel_feedback_queue_scheduler_unit verification failed");
      $finish;
   end
endmodule

FILE: multilevel_feedback_queue_scheduler_unit.f
rtl/core/mlfq_pkg.sv
rtl/core/mlfq_ram.sv
rtl/core/multilevel_feedback_queue_scheduler_unit.sv
bench/multilevel_feedback_queue_scheduler_unit_test.sv
